// ===== design/qwo_pkg.sv =====
// Shared types and constants of the quadrature wheel odometry unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
package qwo_pkg;

  localparam int CountW = 15;
  localparam int ScaleW = 10;
  localparam int RateW  = 14;
  localparam int StepW  = 15;
  localparam int DistW  = 32;
  localparam int TickW  = 16;
  localparam int ProdW  = 25;
  localparam int SpeedW = 39;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 15;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_COUNTER_MAX    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UM_PER_COUNT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UPDATE_RATE_HZ = 2'd2;

  localparam logic [CountW-1:0] RST_COUNTER_MAX    = 15'd2111;
  localparam logic [ScaleW-1:0] RST_UM_PER_COUNT   = 10'd89;
  localparam logic [RateW-1:0]  RST_UPDATE_RATE_HZ = 14'd1000;

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_RATE,
    S_LOAD
  } qwo_state_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic accept;
    logic scale;
    logic rate;
    logic load;
  } qwo_cmd_t;

endpackage

// ===== design/qwo_if.sv =====
// Valid/ready channel interfaces for the sample and result items.
// Depends on qwo_pkg for field widths.
interface qwo_sample_if;
  import qwo_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CountW-1:0] count_left;
  logic [CountW-1:0] count_right;

  modport source (output valid, cmd, count_left, count_right, input ready);
  modport sink   (input valid, cmd, count_left, count_right, output ready);
endinterface

interface qwo_result_if;
  import qwo_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DistW-1:0]  distance_left;
  logic signed [DistW-1:0]  distance_right;
  logic signed [DistW-1:0]  distance_mean;
  logic signed [TickW-1:0]  ticks_left;
  logic signed [TickW-1:0]  ticks_right;
  logic signed [TickW-1:0]  ticks_difference;
  logic signed [StepW-1:0]  step_left;
  logic signed [StepW-1:0]  step_right;
  logic signed [SpeedW-1:0] speed_left;
  logic signed [SpeedW-1:0] speed_right;
  logic signed [SpeedW-1:0] speed_mean;

  modport source (output valid, distance_left, distance_right, distance_mean, ticks_left,
                  ticks_right, ticks_difference, step_left, step_right, speed_left,
                  speed_right, speed_mean, input ready);
  modport sink   (input valid, distance_left, distance_right, distance_mean, ticks_left,
                  ticks_right, ticks_difference, step_left, step_right, speed_left,
                  speed_right, speed_mean, output ready);
endinterface

// ===== design/qwo_ctrl.sv =====
// Sequencer of the odometry unit: steps one item through scale, rate and load.
// Depends on qwo_pkg for the state and command types.
module qwo_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output qwo_pkg::qwo_cmd_t cmd
);
  import qwo_pkg::*;

  qwo_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SCALE;
      S_SCALE: state_next = S_RATE;
      S_RATE:  state_next = S_LOAD;
      S_LOAD:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_SCALE: cmd.scale = 1'b1;
      S_RATE:  cmd.rate  = 1'b1;
      // hold the finished item until the output register is free
      S_LOAD:  cmd.load  = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("result loaded over an item not yet taken");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCALE) ##1 (state == S_RATE))
    else $error("accepted item did not advance through scale and rate");

  a_rose_after_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load))
    else $error("result valid rose without a load");

  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath strobe at once");

endmodule

// ===== design/qwo_dp.sv =====
// Datapath of the odometry unit: config registers, step folding, accumulators,
// the two multiplier stages and the output register. Depends on qwo_pkg.
module qwo_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qwo_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [qwo_pkg::CfgDataW-1:0] cfg_data,
  input  qwo_pkg::qwo_cmd_t           cmd,
  input  logic                        in_cmd,
  input  logic [qwo_pkg::CountW-1:0]  in_count_left,
  input  logic [qwo_pkg::CountW-1:0]  in_count_right,
  qwo_result_if.source                result
);
  import qwo_pkg::*;

  // Fold the raw change into half a counter period, then wrap to the step width
  function automatic logic signed [StepW-1:0] fold_step(
    input logic [CountW-1:0] now,
    input logic [CountW-1:0] prev,
    input logic [CountW-1:0] cmax
  );
    logic signed [CountW+1:0] raw;
    logic signed [CountW+1:0] period;
    logic signed [CountW+1:0] half;
    logic signed [CountW+1:0] res;
    raw    = $signed({2'b00, now}) - $signed({2'b00, prev});
    period = $signed({2'b00, cmax}) + 17'sd1;
    half   = period >>> 1;
    res    = raw;
    if (!raw[CountW+1]) begin
      if (raw >= half) res = raw - period;
    end else begin
      if (raw < -half) res = raw + period;
    end
    return res[StepW-1:0];
  endfunction

  logic [CountW-1:0] counter_max;
  logic [ScaleW-1:0] um_per_count;
  logic [RateW-1:0]  update_rate_hz;

  logic [CountW-1:0] last_count_left, last_count_right;
  logic [DistW-1:0]  travel_left, travel_right;
  logic [TickW-1:0]  angle_left, angle_right;
  logic              clr;
  logic signed [StepW-1:0]  step_left, step_right;
  logic signed [ProdW-1:0]  prod_left, prod_right;
  logic signed [SpeedW-1:0] speed_left, speed_right;

  logic signed [ProdW:0]    prod_left_full, prod_right_full;
  logic signed [SpeedW:0]   speed_left_full, speed_right_full;
  logic [DistW:0]           dist_sum, dist_adj;
  logic [SpeedW:0]          speed_sum, speed_adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_max    <= RST_COUNTER_MAX;
      um_per_count   <= RST_UM_PER_COUNT;
      update_rate_hz <= RST_UPDATE_RATE_HZ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNTER_MAX:    counter_max    <= cfg_data[CountW-1:0];
        CFG_UM_PER_COUNT:   um_per_count   <= cfg_data[ScaleW-1:0];
        CFG_UPDATE_RATE_HZ: update_rate_hz <= cfg_data[RateW-1:0];
        default: ;
      endcase
    end
  end

  assign prod_left_full   = step_left  * $signed({1'b0, um_per_count});
  assign prod_right_full  = step_right * $signed({1'b0, um_per_count});
  assign speed_left_full  = prod_left  * $signed({1'b0, update_rate_hz});
  assign speed_right_full = prod_right * $signed({1'b0, update_rate_hz});

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count_left  <= '0;
      last_count_right <= '0;
      travel_left      <= '0;
      travel_right     <= '0;
      angle_left       <= '0;
      angle_right      <= '0;
    end else begin
      if (cmd.accept && (in_cmd == CMD_SAMPLE)) begin
        last_count_left  <= in_count_left;
        last_count_right <= in_count_right;
      end
      if (cmd.scale) begin
        if (clr) begin
          angle_left  <= '0;
          angle_right <= '0;
        end else begin
          angle_left  <= angle_left  + {step_left[StepW-1], step_left};
          angle_right <= angle_right + {step_right[StepW-1], step_right};
        end
      end
      if (cmd.rate) begin
        travel_left  <= travel_left  + {{(DistW-ProdW){prod_left[ProdW-1]}}, prod_left};
        travel_right <= travel_right + {{(DistW-ProdW){prod_right[ProdW-1]}}, prod_right};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      clr <= (in_cmd == CMD_CLEAR);
      if (in_cmd == CMD_CLEAR) begin
        step_left  <= '0;
        step_right <= '0;
      end else begin
        step_left  <= fold_step(in_count_left,  last_count_left,  counter_max);
        step_right <= fold_step(in_count_right, last_count_right, counter_max);
      end
    end
    if (cmd.scale) begin
      prod_left  <= prod_left_full[ProdW-1:0];
      prod_right <= prod_right_full[ProdW-1:0];
    end
    if (cmd.rate) begin
      speed_left  <= speed_left_full[SpeedW-1:0];
      speed_right <= speed_right_full[SpeedW-1:0];
    end
  end

  // Means truncate toward zero: add one to a negative sum before halving
  assign dist_sum  = {travel_left[DistW-1], travel_left} + {travel_right[DistW-1], travel_right};
  assign dist_adj  = dist_sum + {{DistW{1'b0}}, dist_sum[DistW]};
  assign speed_sum = {speed_left[SpeedW-1], speed_left} + {speed_right[SpeedW-1], speed_right};
  assign speed_adj = speed_sum + {{SpeedW{1'b0}}, speed_sum[SpeedW]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.distance_left    <= travel_left;
      result.distance_right   <= travel_right;
      result.distance_mean    <= dist_adj[DistW:1];
      result.ticks_left       <= angle_left;
      result.ticks_right      <= angle_right;
      result.ticks_difference <= angle_left - angle_right;
      result.step_left        <= step_left;
      result.step_right       <= step_right;
      result.speed_left       <= speed_left;
      result.speed_right      <= speed_right;
      result.speed_mean       <= speed_adj[SpeedW:1];
    end
  end

endmodule

// ===== design/quadrature_wheel_odometry_unit.sv =====
// Quadrature wheel odometry unit, top level.
// Joins the sequencer qwo_ctrl and the datapath qwo_dp; depends on qwo_pkg and qwo_if.
//
// Usage:
//   sample: valid/ready input channel. cmd = 0 samples both wheel counters,
//           cmd = 1 clears the angle tick counts. Each item gives one result.
//   result: valid/ready output channel carrying distances, their mean, ticks,
//           their difference, steps and speeds in um/s.
//   cfg_we/cfg_index/cfg_data: write-only register port (0 counter_max,
//           1 um_per_count, 2 update_rate_hz); write only while idle.
// Timing:
//   An item is accepted in the idle state and steps through fold, step x scale,
//   x rate, then the output load, sequenced through the two registered
//   multiplier stages; its result becomes valid once it is loaded.
//   The output register frees the input side: the next item is taken as soon
//   as the result is loaded, even if it has not yet been taken.
// Reset (rst, synchronous): registers return to their reset values, last
//   counts, distances and ticks are cleared, no result is pending.
// Stall: while a result is pending and result.ready is low, a finished item waits in the load step
//   and sample.ready stays low until the output register is free.
module quadrature_wheel_odometry_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [qwo_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [qwo_pkg::CfgDataW-1:0] cfg_data,
  qwo_sample_if.sink                   sample,
  qwo_result_if.source                 result
);
  import qwo_pkg::*;

  qwo_cmd_t cmd;

  qwo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd)
  );

  qwo_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .in_cmd         (sample.cmd),
    .in_count_left  (sample.count_left),
    .in_count_right (sample.count_right),
    .result         (result)
  );

endmodule

// ===== tb/quadrature_wheel_odometry_unit_tb.sv =====
// Self-checking testbench for quadrature_wheel_odometry_unit.
// Drives sample items and register writes, predicts every result and compares it field by field.
// Depends on qwo_pkg, the channel interfaces in qwo_if and the design sources.
`timescale 1ns / 100ps

typedef struct {
  logic signed [qwo_pkg::DistW-1:0]  distance_left;
  logic signed [qwo_pkg::DistW-1:0]  distance_right;
  logic signed [qwo_pkg::DistW-1:0]  distance_mean;
  logic signed [qwo_pkg::TickW-1:0]  ticks_left;
  logic signed [qwo_pkg::TickW-1:0]  ticks_right;
  logic signed [qwo_pkg::TickW-1:0]  ticks_difference;
  logic signed [qwo_pkg::StepW-1:0]  step_left;
  logic signed [qwo_pkg::StepW-1:0]  step_right;
  logic signed [qwo_pkg::SpeedW-1:0] speed_left;
  logic signed [qwo_pkg::SpeedW-1:0] speed_right;
  logic signed [qwo_pkg::SpeedW-1:0] speed_mean;
} odo_result_t;

class odometry_tracker;
  logic [qwo_pkg::CountW-1:0] counter_max;
  logic [qwo_pkg::ScaleW-1:0] um_per_count;
  logic [qwo_pkg::RateW-1:0]  rate_hz;
  logic [qwo_pkg::CountW-1:0] last_left;
  logic [qwo_pkg::CountW-1:0] last_right;
  logic [qwo_pkg::DistW-1:0]  travel_left;
  logic [qwo_pkg::DistW-1:0]  travel_right;
  logic [qwo_pkg::TickW-1:0]  angle_left;
  logic [qwo_pkg::TickW-1:0]  angle_right;
  odo_result_t due[$];
  int errors;
  int checked;

  function new();
    counter_max  = qwo_pkg::RST_COUNTER_MAX;
    um_per_count = qwo_pkg::RST_UM_PER_COUNT;
    rate_hz      = qwo_pkg::RST_UPDATE_RATE_HZ;
    last_left    = '0;
    last_right   = '0;
    travel_left  = '0;
    travel_right = '0;
    angle_left   = '0;
    angle_right  = '0;
    errors       = 0;
    checked      = 0;
  endfunction

  function void set_register(logic [qwo_pkg::CfgIdxW-1:0] idx,
                             logic [qwo_pkg::CfgDataW-1:0] data);
    case (idx)
      qwo_pkg::CFG_COUNTER_MAX:    counter_max  = data[qwo_pkg::CountW-1:0];
      qwo_pkg::CFG_UM_PER_COUNT:   um_per_count = data[qwo_pkg::ScaleW-1:0];
      qwo_pkg::CFG_UPDATE_RATE_HZ: rate_hz      = data[qwo_pkg::RateW-1:0];
      default: ;
    endcase
  endfunction

  // Fold the raw change into half a counter period, then wrap to the step width.
  function logic signed [qwo_pkg::StepW-1:0] folded_step(logic [qwo_pkg::CountW-1:0] now,
                                                         logic [qwo_pkg::CountW-1:0] prev);
    longint period;
    longint half;
    longint raw;
    period = longint'(counter_max) + 1;
    half   = period / 2;
    raw    = longint'(now) - longint'(prev);
    if (raw >= 0) begin
      if (raw >= half) raw = raw - period;
    end else if (raw < -half) begin
      raw = raw + period;
    end
    return raw[qwo_pkg::StepW-1:0];
  endfunction

  function void take_sample(logic cmd, logic [qwo_pkg::CountW-1:0] cl,
                            logic [qwo_pkg::CountW-1:0] cr);
    odo_result_t r;
    longint sl, sr, vl, vr, dl, dr, tl, tr;
    sl = 0;
    sr = 0;
    vl = 0;
    vr = 0;
    if (cmd == qwo_pkg::CMD_CLEAR) begin
      angle_left  = '0;
      angle_right = '0;
    end else begin
      sl = longint'(folded_step(cl, last_left));
      sr = longint'(folded_step(cr, last_right));
      travel_left  = travel_left + 32'(sl * longint'(um_per_count));
      travel_right = travel_right + 32'(sr * longint'(um_per_count));
      angle_left   = angle_left + 16'(sl);
      angle_right  = angle_right + 16'(sr);
      vl = sl * longint'(um_per_count) * longint'(rate_hz);
      vr = sr * longint'(um_per_count) * longint'(rate_hz);
      last_left  = cl;
      last_right = cr;
    end
    dl = longint'($signed(travel_left));
    dr = longint'($signed(travel_right));
    tl = longint'($signed(angle_left));
    tr = longint'($signed(angle_right));
    r.distance_left    = travel_left;
    r.distance_right   = travel_right;
    r.distance_mean    = 32'((dl + dr) / 2);
    r.ticks_left       = angle_left;
    r.ticks_right      = angle_right;
    r.ticks_difference = 16'(tl - tr);
    r.step_left        = 15'(sl);
    r.step_right       = 15'(sr);
    r.speed_left       = 39'(vl);
    r.speed_right      = 39'(vr);
    r.speed_mean       = 39'((vl + vr) / 2);
    due.push_back(r);
  endfunction

  function int pending();
    return due.size();
  endfunction

  task report(string what, logic signed [63:0] got, logic signed [63:0] want);
    $display("mismatch at result %0d: %s got %0d, expected %0d", checked, what, got, want);
    errors++;
  endtask

  task compare_field(string what, logic signed [63:0] got, logic signed [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task check_result(odo_result_t got);
    odo_result_t want;
    if (due.size() == 0) begin
      report("result with no item outstanding", 0, 0);
      return;
    end
    want = due.pop_front();
    checked++;
    compare_field("distance_left", got.distance_left, want.distance_left);
    compare_field("distance_right", got.distance_right, want.distance_right);
    compare_field("distance_mean", got.distance_mean, want.distance_mean);
    compare_field("ticks_left", got.ticks_left, want.ticks_left);
    compare_field("ticks_right", got.ticks_right, want.ticks_right);
    compare_field("ticks_difference", got.ticks_difference, want.ticks_difference);
    compare_field("step_left", got.step_left, want.step_left);
    compare_field("step_right", got.step_right, want.step_right);
    compare_field("speed_left", got.speed_left, want.speed_left);
    compare_field("speed_right", got.speed_right, want.speed_right);
    compare_field("speed_mean", got.speed_mean, want.speed_mean);
  endtask
endclass

module quadrature_wheel_odometry_unit_tb;
  import qwo_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  qwo_sample_if sample_ch ();
  qwo_result_if result_ch ();

  quadrature_wheel_odometry_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  odometry_tracker tracker;
  bit reset_done;
  bit tx_quiet;
  bit rx_quiet;
  int rx_hold;
  int n_items;
  int n_clears;
  int n_settings;
  int unsigned cycle_count;
  logic [CountW-1:0] walk_left;
  logic [CountW-1:0] walk_right;
  logic [CountW-1:0] cur_cmax;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tracker.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly plausible wheel movement, some steps right at the fold edge, some noise.
  function automatic logic [CountW-1:0] next_count(logic [CountW-1:0] prev);
    longint period;
    longint half;
    longint delta;
    longint span;
    int pick;
    period = longint'(cur_cmax) + 1;
    half   = period / 2;
    pick   = $urandom_range(0, 99);
    if (pick >= 88) return CountW'($urandom);
    if (pick >= 74) begin
      delta = half + longint'($urandom_range(0, 2)) - 1;
    end else begin
      span  = (pick < 50 && half > 40) ? 40 : half;
      delta = longint'($urandom_range(0, int'(span)));
    end
    if ($urandom_range(0, 1) == 1) delta = -delta;
    return CountW'((((longint'(prev) + delta) % period) + period) % period);
  endfunction

  task automatic offer_sample(logic cmd, logic [CountW-1:0] cl, logic [CountW-1:0] cr);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.cmd         <= cmd;
    sample_ch.count_left  <= cl;
    sample_ch.count_right <= cr;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.take_sample(cmd, cl, cr);
    n_items++;
    if (cmd == CMD_CLEAR) begin
      n_clears++;
    end else begin
      walk_left  = cl;
      walk_right = cr;
    end
  endtask

  task automatic wander(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 8) begin
        offer_sample(CMD_CLEAR, CountW'($urandom), CountW'($urandom));
      end else begin
        offer_sample(CMD_SAMPLE, next_count(walk_left), next_count(walk_right));
      end
    end
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
  endtask

  task automatic program_registers(logic [CfgDataW-1:0] cm, logic [CfgDataW-1:0] sc,
                                   logic [CfgDataW-1:0] rt, bit spare);
    write_register(CFG_COUNTER_MAX, cm);
    write_register(CFG_UM_PER_COUNT, sc);
    write_register(CFG_UPDATE_RATE_HZ, rt);
    if (spare) write_register(CFG_SPARE, 15'h7fff);
    cfg_we   <= 1'b0;
    cur_cmax  = cm;
    n_settings++;
  endtask

  initial begin : drain_results
    odo_result_t seen;
    int stall;
    result_ch.ready = 1'b0;
    wait (reset_done);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = pick_gap(rx_quiet);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      seen.distance_left    = result_ch.distance_left;
      seen.distance_right   = result_ch.distance_right;
      seen.distance_mean    = result_ch.distance_mean;
      seen.ticks_left       = result_ch.ticks_left;
      seen.ticks_right      = result_ch.ticks_right;
      seen.ticks_difference = result_ch.ticks_difference;
      seen.step_left        = result_ch.step_left;
      seen.step_right       = result_ch.step_right;
      seen.speed_left       = result_ch.speed_left;
      seen.speed_right      = result_ch.speed_right;
      seen.speed_mean       = result_ch.speed_mean;
      tracker.check_result(seen);
    end
  end

  initial begin : stimulus
    int k;
    int sel;
    logic [CfgDataW-1:0] cm;
    logic [CfgDataW-1:0] sc;
    logic [CfgDataW-1:0] rt;
    tracker               = new();
    cycle_count           = 0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.cmd         = CMD_SAMPLE;
    sample_ch.count_left  = '0;
    sample_ch.count_right = '0;
    walk_left             = '0;
    walk_right            = '0;
    cur_cmax              = RST_COUNTER_MAX;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reset_done = 1'b1;

    // Reset settings: fold edges either side of half a period, counts above counter_max.
    offer_sample(CMD_SAMPLE, 15'd0, 15'd0);
    offer_sample(CMD_SAMPLE, 15'd1055, 15'd1056);
    offer_sample(CMD_SAMPLE, 15'd0, 15'd0);
    offer_sample(CMD_SAMPLE, 15'd2111, 15'd2111);
    offer_sample(CMD_SAMPLE, 15'd0, 15'd0);
    offer_sample(CMD_SAMPLE, 15'h7fff, 15'h5555);
    offer_sample(CMD_SAMPLE, 15'd0, 15'h2aaa);
    offer_sample(CMD_CLEAR, 15'h7fff, 15'h7fff);
    offer_sample(CMD_SAMPLE, 15'd100, 15'd200);
    offer_sample(CMD_CLEAR, 15'd0, 15'd0);

    // Largest period, scale and rate; the rate write carries a bit above its width.
    settle();
    program_registers(15'd32767, 15'd1023, 15'h4000 | 15'd10000, 1'b0);
    offer_sample(CMD_SAMPLE, 15'd0, 15'd0);
    offer_sample(CMD_SAMPLE, 15'd16383, 15'd16384);
    offer_sample(CMD_SAMPLE, 15'd32767, 15'd0);
    offer_sample(CMD_SAMPLE, 15'd0, 15'd32767);
    offer_sample(CMD_CLEAR, 15'd0, 15'd0);

    // Smallest legal settings, where any count above one wraps the step.
    settle();
    program_registers(15'd1, 15'd1, 15'd1, 1'b0);
    offer_sample(CMD_SAMPLE, 15'd0, 15'd0);
    offer_sample(CMD_SAMPLE, 15'd1, 15'd0);
    offer_sample(CMD_SAMPLE, 15'd0, 15'd1);
    offer_sample(CMD_SAMPLE, 15'd32767, 15'd2);
    offer_sample(CMD_SAMPLE, 15'd0, 15'd0);
    offer_sample(CMD_CLEAR, 15'd1, 15'd1);
    wander(10);

    // Zero settings and a write to the unused index, which must change nothing.
    settle();
    program_registers(15'd0, 15'd0, 15'd0, 1'b1);
    wander(16);

    for (k = 0; k < 8; k++) begin
      settle();
      sel = $urandom_range(0, 3);
      case (sel)
        0:       cm = CfgDataW'($urandom_range(1, 15));
        1:       cm = CfgDataW'($urandom_range(16, 4095));
        2:       cm = CfgDataW'($urandom_range(4096, 32766));
        default: cm = 15'd32767;
      endcase
      sel = $urandom_range(0, 9);
      sc  = (sel < 2) ? 15'd1023 : (sel < 4) ? 15'd1 : CfgDataW'($urandom_range(1, 1023));
      sel = $urandom_range(0, 9);
      rt  = (sel < 2) ? 15'd10000 : (sel < 4) ? 15'd1 : CfgDataW'($urandom_range(1, 10000));
      program_registers(cm, sc, rt, 1'b0);
      tx_quiet = (k == 2 || k == 5);
      rx_quiet = (k == 2);
      // Hold the output side off while items keep coming, so the input stalls.
      if (k == 5) rx_hold = HOLD_CYCLES;
      wander(60);
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
    end

    settle();
    $display("Covered %0d items (%0d clears) over %0d register settings plus reset values.",
             n_items, n_clears, n_settings);
    $display("Checked %0d results, with random stalls and one %0d-cycle output hold-off.",
             tracker.checked, HOLD_CYCLES);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
